>>> hdl/opstc_pkg.sv
// ============================================================================
// opstc_pkg - shared types and constants for the oven panel controller
// Request and key codes, edit field codes, register indexes, reset values and
// the command / status structs between the controller and the datapath.
// ============================================================================
package opstc_pkg;

    localparam int WORD_W        = 16;
    localparam int PRESET_COUNT  = 4;
    localparam int EDIT_FIELDS   = 3;
    localparam int PRESET_SLOTS  = 4;   // entries held in one preset register
    localparam int SLOT_W        = 2;
    localparam int REQ_W         = 3;
    localparam int KEY_W         = 4;
    localparam int EDIT_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = WORD_W * PRESET_SLOTS;
    localparam int IN_TDATA_W    = 24;  // key_code + new_target, padded to bytes
    localparam int OUT_TDATA_W   = 56;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CFG_DATA_W-1:0]    t_table;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_KEY        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READY      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NOT_READY  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TIMER_ON   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TIMER_OFF  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LED        = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SET_TARGET = 3'd7;

    // key codes
    localparam logic [KEY_W-1:0] KEY_P100   = 4'd0;
    localparam logic [KEY_W-1:0] KEY_P10    = 4'd1;
    localparam logic [KEY_W-1:0] KEY_P1     = 4'd2;
    localparam logic [KEY_W-1:0] KEY_STOP   = 4'd3;
    localparam logic [KEY_W-1:0] KEY_SELECT = 4'd4;
    localparam logic [KEY_W-1:0] KEY_RUN    = 4'd5;
    localparam logic [KEY_W-1:0] KEY_M100   = 4'd6;
    localparam logic [KEY_W-1:0] KEY_M10    = 4'd7;
    localparam logic [KEY_W-1:0] KEY_M1     = 4'd8;

    // edit field codes
    localparam logic [EDIT_W-1:0] EDIT_NONE = 2'd0;
    localparam logic [EDIT_W-1:0] EDIT_TEMP = 2'd1;
    localparam logic [EDIT_W-1:0] EDIT_MIN  = 2'd2;
    localparam logic [EDIT_W-1:0] EDIT_SEC  = 2'd3;
    localparam logic [EDIT_W-1:0] EDIT_LAST = EDIT_W'(EDIT_FIELDS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_TEMP = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_MIN  = 3'd7;

    // register reset values
    localparam t_word RST_MAX_TEMP = 16'sd300;
    localparam t_word RST_MIN_TEMP = 16'sd0;
    localparam t_word RST_MAX_MIN  = 16'sd99;
    localparam t_word RST_MIN_MIN  = 16'sd0;
    localparam t_word RST_MAX_SEC  = 16'sd60;
    localparam t_word RST_MIN_SEC  = 16'sd0;

    localparam t_word STEP_100 = 16'sd100;
    localparam t_word STEP_10  = 16'sd10;
    localparam t_word STEP_1   = 16'sd1;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PRESET_COUNT - 1);

    typedef struct packed {
        logic load;      // latch the request
        logic exec;      // apply the request to the state
        logic search;    // one preset table step
        logic out_load;  // capture the result into the output register
    } t_cmd;

    typedef struct packed {
        logic need_search;
        logic search_last;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/opstc_ctrl.sv
// ============================================================================
// opstc_ctrl - request sequencer
// Steps one request through execute, optional preset search and result load.
// ============================================================================
module opstc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  opstc_pkg::t_sts   i_sts,
    output opstc_pkg::t_cmd   o_cmd
);
    import opstc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_search ? ST_SEARCH : ST_DONE;
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/opstc_dp.sv
// ============================================================================
// opstc_dp - panel state and arithmetic
// Config registers, panel state, field step/clamp, countdown, preset search
// and the output register.
// ============================================================================
module opstc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  opstc_pkg::t_cmd                     i_cmd,
    output opstc_pkg::t_sts                     o_sts,
    input  logic [opstc_pkg::REQ_W-1:0]         i_req_type,
    input  logic [opstc_pkg::KEY_W-1:0]         i_key_code,
    input  opstc_pkg::t_word                    i_new_target,
    input  logic                                i_cfg_we,
    input  logic [opstc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [opstc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [opstc_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import opstc_pkg::*;

    // configuration
    t_word  r_max_temp, r_min_temp, r_max_min, r_min_min, r_max_sec, r_min_sec;
    t_table r_pre_temp, r_pre_min;

    // latched request
    logic [REQ_W-1:0] r_req_type;
    logic [KEY_W-1:0] r_key;
    t_word            r_new_target;

    // panel state
    t_word             r_target, r_min, r_sec;
    logic [EDIT_W-1:0] r_edit;
    logic              r_running, r_ready, r_timer, r_fan, r_blink, r_led, r_stop;
    t_word             n_target, n_min, n_sec;
    logic [EDIT_W-1:0] n_edit;
    logic              n_running, n_ready, n_timer, n_fan, n_blink, n_led, n_stop;

    // preset search
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              r_found_t, r_found_m, n_found_t, n_found_m;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // field step and clamp
    t_word cur, hi, lo, step, sum, clamped;
    logic  dec;
    // countdown
    t_word min_dec, min_cl, sec_dec, sec_cl, sec_reload;
    // preset lookup
    logic              up, run_now;
    logic [SLOT_W-1:0] slot;
    t_word             pt, pm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_temp <= RST_MAX_TEMP;
            r_min_temp <= RST_MIN_TEMP;
            r_max_min  <= RST_MAX_MIN;
            r_min_min  <= RST_MIN_MIN;
            r_max_sec  <= RST_MAX_SEC;
            r_min_sec  <= RST_MIN_SEC;
            r_pre_temp <= '0;
            r_pre_min  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_TEMP: r_max_temp <= i_cfg_data[WORD_W-1:0];
                CFG_MIN_TEMP: r_min_temp <= i_cfg_data[WORD_W-1:0];
                CFG_MAX_MIN:  r_max_min  <= i_cfg_data[WORD_W-1:0];
                CFG_MIN_MIN:  r_min_min  <= i_cfg_data[WORD_W-1:0];
                CFG_MAX_SEC:  r_max_sec  <= i_cfg_data[WORD_W-1:0];
                CFG_MIN_SEC:  r_min_sec  <= i_cfg_data[WORD_W-1:0];
                CFG_PRE_TEMP: r_pre_temp <= i_cfg_data;
                CFG_PRE_MIN:  r_pre_min  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type   <= i_req_type;
            r_key        <= i_key_code;
            r_new_target <= i_new_target;
        end
    end

    // edited field and its limits
    always_comb begin
        unique case (r_edit)
            EDIT_TEMP: begin cur = r_target; hi = r_max_temp; lo = r_min_temp; end
            EDIT_MIN:  begin cur = r_min;    hi = r_max_min;  lo = r_min_min;  end
            EDIT_SEC:  begin cur = r_sec;    hi = r_max_sec;  lo = r_min_sec;  end
            default:   begin cur = r_target; hi = r_max_temp; lo = r_min_temp; end
        endcase
    end

    always_comb begin
        unique case (r_key)
            KEY_P100: begin step = STEP_100; dec = 1'b0; end
            KEY_P10:  begin step = STEP_10;  dec = 1'b0; end
            KEY_M100: begin step = STEP_100; dec = 1'b1; end
            KEY_M10:  begin step = STEP_10;  dec = 1'b1; end
            KEY_M1:   begin step = STEP_1;   dec = 1'b1; end
            default:  begin step = STEP_1;   dec = 1'b0; end
        endcase
    end

    // wrap to 16 bits, then clamp
    assign sum     = dec ? (cur - step) : (cur + step);
    assign clamped = dec ? ((sum < lo) ? lo : sum) : ((sum > hi) ? hi : sum);

    assign min_dec    = r_min - STEP_1;
    assign min_cl     = (min_dec < r_min_min) ? r_min_min : min_dec;
    assign sec_dec    = r_sec - STEP_1;
    assign sec_cl     = (sec_dec < r_min_sec) ? r_min_sec : sec_dec;
    assign sec_reload = r_max_sec - STEP_1;

    // +1 walks the table upwards, -1 downwards
    assign up   = (r_key == KEY_P1);
    assign slot = up ? r_cnt : (SLOT_LAST - r_cnt);
    assign pt   = r_pre_temp[{slot, 4'd0} +: WORD_W];
    assign pm   = r_pre_min[{slot, 4'd0} +: WORD_W];

    assign run_now = r_running | (r_edit == EDIT_NONE);

    always_comb begin
        n_target  = r_target;
        n_min     = r_min;
        n_sec     = r_sec;
        n_edit    = r_edit;
        n_running = r_running;
        n_ready   = r_ready;
        n_timer   = r_timer;
        n_fan     = r_fan;
        n_blink   = r_blink;
        n_led     = r_led;
        n_stop    = r_stop;
        n_cnt     = r_cnt;
        n_found_t = r_found_t;
        n_found_m = r_found_m;
        if (i_cmd.exec) begin
            n_stop    = 1'b0;
            n_cnt     = '0;
            n_found_t = 1'b0;
            n_found_m = 1'b0;
            unique case (r_req_type)
                REQ_KEY: begin
                    case (r_key) inside
                        KEY_STOP: begin
                            n_running = 1'b0;
                            n_stop    = 1'b1;
                        end
                        KEY_SELECT: begin
                            n_running = 1'b0;
                            n_stop    = 1'b1;
                            n_edit    = (r_edit == EDIT_LAST) ? EDIT_NONE : r_edit + 2'd1;
                        end
                        KEY_RUN: begin
                            n_running = run_now;
                            if (run_now && r_ready && !r_timer) begin
                                n_timer = 1'b1;
                            end
                        end
                        KEY_P100, KEY_P10, KEY_P1, KEY_M100, KEY_M10, KEY_M1: begin
                            // preset steps with no field selected run in the search phase
                            if (!r_running) begin
                                unique case (r_edit)
                                    EDIT_TEMP: n_target = clamped;
                                    EDIT_MIN:  n_min    = clamped;
                                    EDIT_SEC:  n_sec    = clamped;
                                    default: begin
                                        if (r_key == KEY_M100) begin
                                            n_fan = ~r_fan;
                                        end
                                    end
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                REQ_TICK: begin
                    if (r_running) begin
                        if (r_sec <= 0 && r_min <= 0) begin
                            n_running = 1'b0;
                            n_stop    = 1'b1;
                        end else if (r_sec <= 0) begin
                            n_min = min_cl;
                            n_sec = sec_reload;
                        end else begin
                            n_sec = sec_cl;
                        end
                    end
                end
                REQ_READY: n_ready = 1'b1;
                REQ_NOT_READY: begin
                    n_ready = 1'b0;
                    n_timer = 1'b0;
                end
                REQ_TIMER_ON:  n_timer = 1'b1;
                REQ_TIMER_OFF: n_timer = 1'b0;
                REQ_LED: begin
                    if (!r_ready) begin
                        n_blink = ~r_blink;
                        n_led   = ~r_blink;
                    end else begin
                        n_led = ~r_timer;
                    end
                end
                REQ_SET_TARGET: n_target = r_new_target;
                default: ;
            endcase
        end else if (i_cmd.search) begin
            n_cnt = r_cnt + 2'd1;
            if (!r_found_t && (up ? (pt > r_target) : (pt < r_target))) begin
                n_target  = pt;
                n_found_t = 1'b1;
            end
            if (!r_found_m && (up ? (pm > r_min) : (pm < r_min))) begin
                n_min     = pm;
                n_found_m = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_min     <= '0;
            r_sec     <= '0;
            r_edit    <= EDIT_NONE;
            r_running <= 1'b0;
            r_ready   <= 1'b0;
            r_timer   <= 1'b0;
            r_fan     <= 1'b0;
            r_blink   <= 1'b0;
            r_led     <= 1'b0;
            r_stop    <= 1'b0;
            r_cnt     <= '0;
            r_found_t <= 1'b0;
            r_found_m <= 1'b0;
        end else begin
            r_target  <= n_target;
            r_min     <= n_min;
            r_sec     <= n_sec;
            r_edit    <= n_edit;
            r_running <= n_running;
            r_ready   <= n_ready;
            r_timer   <= n_timer;
            r_fan     <= n_fan;
            r_blink   <= n_blink;
            r_led     <= n_led;
            r_stop    <= n_stop;
            r_cnt     <= n_cnt;
            r_found_t <= n_found_t;
            r_found_m <= n_found_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_stop, r_led, r_fan, r_timer, r_ready, r_running,
                           r_edit, r_sec, r_min, r_target};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.search_last = (r_cnt == SLOT_LAST);
    assign o_sts.need_search = (r_req_type == REQ_KEY) && !r_running && (r_edit == EDIT_NONE)
                               && ((r_key == KEY_P1) || (r_key == KEY_M1));

endmodule

>>> hdl/oven_panel_setpoint_timer_controller.sv
// ============================================================================
// oven_panel_setpoint_timer_controller - oven front-panel controller
// Keeps target temperature, countdown timer, edit field and panel flags.
// ============================================================================
//  - Requests arrive on s_axis, one per transfer: tuser carries the request
//    kind, tdata the key code and a new target temperature. Every request
//    yields one result transfer on m_axis with the panel state after it.
//  - Timing: an accepted request is latched, executed, then loaded into the
//    output register; the next request is accepted once that load is done.
//    A +1 or -1 key with no field selected walks the four preset entries,
//    one per cycle, between execute and the load.
//  - Receiver stall: a new request may be taken while the previous result
//    waits in the output register; its own result then waits in the
//    sequencer with s_axis_tready low until that register frees up.
//  - Configuration writes (i_cfg_*) take effect at the edge with the write
//    enable high; the user must issue them only while the block is idle, as the block does not enforce it.
//  - Synchronous active-low reset restores the config defaults, clears the
//    panel state and empties the output register.
// ============================================================================
module oven_panel_setpoint_timer_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] key_code, [19:4] new_target, [23:20] zero
    input  logic [opstc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] req_type
    input  logic [opstc_pkg::REQ_W-1:0]         s_axis_tuser,
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] target_temperature, [31:16] timer_minutes, [47:32] timer_seconds,
    // [49:48] edit_field, [50] oven_running, [51] oven_ready,
    // [52] timer_working, [53] fan_on, [54] red_led, [55] heater_stop
    output logic [opstc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [opstc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [opstc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import opstc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: one request at a time
    opstc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // state, arithmetic and output register
    opstc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (s_axis_tuser),
        .i_key_code   (s_axis_tdata[KEY_W-1:0]),
        .i_new_target (s_axis_tdata[KEY_W +: WORD_W]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata)
    );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - oven panel controller testbench
// Drives panel requests over the request stream, keeps a cycle-free model of
// the panel state in step with every accepted transfer, and checks every
// result transfer against it field by field. Directed tests cover editing,
// preset stepping, the countdown and a long receiver hold-off. Random phases
// then run under several limit settings, with bursty sending and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import opstc_pkg::*;

    localparam int          CFG_REGS        = 1 << CFG_IDX_W;
    localparam int          SETTLE_CYCLES   = 16;   // well past the preset walk
    localparam int          RANDOM_PHASES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = 145;
    localparam int unsigned HOLD_OFF_LEN    = 400;
    localparam longint      TIMEOUT_NS      = 3_000_000;

    localparam t_word WORD_MAX = 16'sh7FFF;
    localparam t_word WORD_MIN = 16'sh8000;

    // key codes with no function
    localparam logic [KEY_W-1:0] KEY_UNUSED_LO = KEY_M1 + 1'b1;
    localparam logic [KEY_W-1:0] KEY_UNUSED_HI = '1;

    // result layout, highest bit first, so it overlays m_axis_tdata directly
    typedef struct packed {
        logic              heater_stop;
        logic              red_led;
        logic              fan_on;
        logic              timer_working;
        logic              oven_ready;
        logic              oven_running;
        logic [EDIT_W-1:0] edit_field;
        t_word             timer_seconds;
        t_word             timer_minutes;
        t_word             target_temperature;
    } t_panel_state;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [REQ_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // panel model state
    t_word             tgt_q, min_q, sec_q;
    logic [EDIT_W-1:0] edit_q;
    bit                run_q, rdy_q, tmr_q, fan_q, blink_q, led_q;

    // limits and preset tables as currently programmed
    t_word  lim_max_temp, lim_min_temp, lim_max_min, lim_min_min;
    t_word  lim_max_sec, lim_min_sec;
    t_table temp_presets, minute_presets;
    t_table cfg_plan [CFG_REGS];

    t_panel_state expected_panel_q [$];

    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned hold_off_cycles;   // receiver holds tready low while non-zero
    int unsigned burst_left;
    bit          pacing_on;         // sender gaps between bursts

    oven_panel_setpoint_timer_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Panel model
    // ------------------------------------------------------------------------
    function automatic t_word step_up(t_word v, t_word step, t_word hi);
        t_word r;
        r = v + step;               // 16-bit wrap first, clamp after
        return (r > hi) ? hi : r;
    endfunction

    function automatic t_word step_down(t_word v, t_word step, t_word lo);
        t_word r;
        r = v - step;
        return (r < lo) ? lo : r;
    endfunction

    // first entry above v in table order, else v unchanged
    function automatic t_word preset_above(t_table tbl, t_word v);
        t_word p;
        for (int i = 0; i < PRESET_COUNT; i++) begin
            p = tbl[WORD_W*i +: WORD_W];
            if (p > v) return p;
        end
        return v;
    endfunction

    // last entry below v in table order, else v unchanged
    function automatic t_word preset_below(t_table tbl, t_word v);
        t_word p;
        for (int i = PRESET_COUNT - 1; i >= 0; i--) begin
            p = tbl[WORD_W*i +: WORD_W];
            if (p < v) return p;
        end
        return v;
    endfunction

    function automatic void reset_panel_model();
        tgt_q   = '0;
        min_q   = '0;
        sec_q   = '0;
        edit_q  = EDIT_NONE;
        run_q   = 1'b0;
        rdy_q   = 1'b0;
        tmr_q   = 1'b0;
        fan_q   = 1'b0;
        blink_q = 1'b0;
        led_q   = 1'b0;
        lim_max_temp   = RST_MAX_TEMP;
        lim_min_temp   = RST_MIN_TEMP;
        lim_max_min    = RST_MAX_MIN;
        lim_min_min    = RST_MIN_MIN;
        lim_max_sec    = RST_MAX_SEC;
        lim_min_sec    = RST_MIN_SEC;
        temp_presets   = '0;
        minute_presets = '0;
    endfunction

    function automatic bit apply_key(logic [KEY_W-1:0] key);
        t_word fv, hi, lo;
        bit    stop;
        stop = 1'b0;
        fv   = '0;
        hi   = '0;
        lo   = '0;
        if (key == KEY_STOP) begin
            run_q = 1'b0;
            stop  = 1'b1;
        end else if (key == KEY_SELECT) begin
            run_q  = 1'b0;
            edit_q = edit_q + 1'b1;     // none, temp, min, sec, none...
            stop   = 1'b1;
        end else if (key == KEY_RUN) begin
            if (edit_q == EDIT_NONE) run_q = 1'b1;
            if (run_q && rdy_q) tmr_q = 1'b1;
        end else if (key <= KEY_M1 && !run_q) begin
            if (edit_q == EDIT_NONE) begin
                // no field: presets on +1/-1, fan on -100, rest ignored
                case (key)
                    KEY_P1: begin
                        tgt_q = preset_above(temp_presets, tgt_q);
                        min_q = preset_above(minute_presets, min_q);
                    end
                    KEY_M1: begin
                        tgt_q = preset_below(temp_presets, tgt_q);
                        min_q = preset_below(minute_presets, min_q);
                    end
                    KEY_M100: fan_q = !fan_q;
                    default: ;
                endcase
            end else begin
                case (edit_q)
                    EDIT_TEMP: begin
                        fv = tgt_q; hi = lim_max_temp; lo = lim_min_temp;
                    end
                    EDIT_MIN: begin
                        fv = min_q; hi = lim_max_min; lo = lim_min_min;
                    end
                    default: begin
                        fv = sec_q; hi = lim_max_sec; lo = lim_min_sec;
                    end
                endcase
                case (key)
                    KEY_P100: fv = step_up(fv, STEP_100, hi);
                    KEY_P10:  fv = step_up(fv, STEP_10, hi);
                    KEY_P1:   fv = step_up(fv, STEP_1, hi);
                    KEY_M100: fv = step_down(fv, STEP_100, lo);
                    KEY_M10:  fv = step_down(fv, STEP_10, lo);
                    default:  fv = step_down(fv, STEP_1, lo);
                endcase
                case (edit_q)
                    EDIT_TEMP: tgt_q = fv;
                    EDIT_MIN:  min_q = fv;
                    default:   sec_q = fv;
                endcase
            end
        end
        return stop;
    endfunction

    function automatic bit apply_tick();
        if (!run_q) return 1'b0;
        if (sec_q <= 0 && min_q <= 0) begin
            run_q = 1'b0;
            return 1'b1;
        end
        if (sec_q <= 0) begin
            // minute borrow clamps at the minutes floor
            min_q = step_down(min_q, STEP_1, lim_min_min);
            sec_q = lim_max_sec - STEP_1;
        end else begin
            sec_q = step_down(sec_q, STEP_1, lim_min_sec);
        end
        return 1'b0;
    endfunction

    // advance the model by one accepted request and queue the panel it shows
    function automatic void apply_panel_request(logic [REQ_W-1:0] req,
                                                logic [KEY_W-1:0] key, t_word new_tgt);
        t_panel_state ps;
        bit           stop;
        stop = 1'b0;
        case (req)
            REQ_KEY:       stop = apply_key(key);
            REQ_TICK:      stop = apply_tick();
            REQ_READY:     rdy_q = 1'b1;
            REQ_NOT_READY: begin
                rdy_q = 1'b0;
                tmr_q = 1'b0;
            end
            REQ_TIMER_ON:  tmr_q = 1'b1;
            REQ_TIMER_OFF: tmr_q = 1'b0;
            REQ_LED: begin
                if (!rdy_q) begin
                    blink_q = !blink_q;
                    led_q   = blink_q;
                end else begin
                    led_q = !tmr_q;
                end
            end
            default:       tgt_q = new_tgt;
        endcase
        ps.target_temperature = tgt_q;
        ps.timer_minutes      = min_q;
        ps.timer_seconds      = sec_q;
        ps.edit_field         = edit_q;
        ps.oven_running       = run_q;
        ps.oven_ready         = rdy_q;
        ps.timer_working      = tmr_q;
        ps.fan_on             = fan_q;
        ps.red_led            = led_q;
        ps.heater_stop        = stop;
        expected_panel_q.push_back(ps);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch on result %0d, %s: expected 0x%h, got 0x%h",
                         results_checked, name, want, got);
        end
    endfunction

    // outputs only move at the rising edge, so sampling at the falling edge
    // sees exactly what the next edge will transfer
    initial begin : result_checker
        t_panel_state want, got;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_panel_state'(m_axis_tdata);
                if (expected_panel_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result 0x%h with nothing pending",
                                 m_axis_tdata);
                end else begin
                    want = expected_panel_q.pop_front();
                    compare_field("target_temperature", want.target_temperature,
                                  got.target_temperature);
                    compare_field("timer_minutes", want.timer_minutes, got.timer_minutes);
                    compare_field("timer_seconds", want.timer_seconds, got.timer_seconds);
                    compare_field("edit_field", want.edit_field, got.edit_field);
                    compare_field("oven_running", want.oven_running, got.oven_running);
                    compare_field("oven_ready", want.oven_ready, got.oven_ready);
                    compare_field("timer_working", want.timer_working, got.timer_working);
                    compare_field("fan_on", want.fan_on, got.fan_on);
                    compare_field("red_led", want.red_led, got.red_led);
                    compare_field("heater_stop", want.heater_stop, got.heater_stop);
                end
                results_checked++;
            end
        end
    end

    // Receiver: long hold-off on request, otherwise a stall mode that is re-picked
    // at random whenever its run ends - always ready, coin toss, mostly stalled, or
    // ready one cycle in three.
    initial begin : result_receiver
        int unsigned mode, mode_left, beat;
        mode          = 0;
        mode_left     = 0;
        beat          = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                beat++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (beat % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Called at a rising edge; returns at the edge that took the transfer, with
    // tvalid still high so a following call can keep the bus busy.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                                input t_word new_tgt);
        int unsigned gap;
        gap = 0;
        if (pacing_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= IN_TDATA_W'({new_tgt, key});
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        apply_panel_request(req, key, new_tgt);
        requests_sent++;
    endtask

    // drop tvalid and wait until every queued result has been transferred
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_panel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_table as_reg(t_word w);
        t_table r;
        r = '0;
        r[WORD_W-1:0] = w;
        return r;
    endfunction

    // writes every register from cfg_plan, one per cycle; block must be idle
    task automatic program_registers();
        for (int r = 0; r < CFG_REGS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(r);
            i_cfg_data <= cfg_plan[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        lim_max_temp   = cfg_plan[CFG_MAX_TEMP][WORD_W-1:0];
        lim_min_temp   = cfg_plan[CFG_MIN_TEMP][WORD_W-1:0];
        lim_max_min    = cfg_plan[CFG_MAX_MIN][WORD_W-1:0];
        lim_min_min    = cfg_plan[CFG_MIN_MIN][WORD_W-1:0];
        lim_max_sec    = cfg_plan[CFG_MAX_SEC][WORD_W-1:0];
        lim_min_sec    = cfg_plan[CFG_MIN_SEC][WORD_W-1:0];
        temp_presets   = cfg_plan[CFG_PRE_TEMP];
        minute_presets = cfg_plan[CFG_PRE_MIN];
    endtask

    function automatic void plan_reset_limits();
        cfg_plan[CFG_MAX_TEMP] = as_reg(RST_MAX_TEMP);
        cfg_plan[CFG_MIN_TEMP] = as_reg(RST_MIN_TEMP);
        cfg_plan[CFG_MAX_MIN]  = as_reg(RST_MAX_MIN);
        cfg_plan[CFG_MIN_MIN]  = as_reg(RST_MIN_MIN);
        cfg_plan[CFG_MAX_SEC]  = as_reg(RST_MAX_SEC);
        cfg_plan[CFG_MIN_SEC]  = as_reg(RST_MIN_SEC);
    endfunction

    function automatic t_word rand_word();
        return t_word'($urandom);
    endfunction

    // limit values lean on the extremes and on the small working range
    function automatic t_word pick_limit();
        case ($urandom_range(0, 4))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2, 3: return t_word'(int'($urandom_range(0, 200)) - 40);
            default: return rand_word();
        endcase
    endfunction

    // mostly an ascending table in the working range, sometimes raw bits
    function automatic t_table pick_presets();
        t_word  slot [PRESET_SLOTS];
        t_word  swap;
        t_table tbl;
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        for (int i = 0; i < PRESET_SLOTS; i++)
            slot[i] = t_word'(int'($urandom_range(0, 400)) - 100);
        for (int i = 0; i < PRESET_SLOTS - 1; i++) begin
            for (int j = 0; j < PRESET_SLOTS - 1 - i; j++) begin
                if (slot[j] > slot[j+1]) begin
                    swap      = slot[j];
                    slot[j]   = slot[j+1];
                    slot[j+1] = swap;
                end
            end
        end
        for (int i = 0; i < PRESET_SLOTS; i++) tbl[WORD_W*i +: WORD_W] = slot[i];
        return tbl;
    endfunction

    function automatic logic [KEY_W-1:0] pick_step_key();
        case ($urandom_range(0, 5))
            0: return KEY_P100;
            1: return KEY_P10;
            2: return KEY_P1;
            3: return KEY_M100;
            4: return KEY_M10;
            default: return KEY_M1;
        endcase
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] key);
        send_request(REQ_KEY, key, rand_word());
    endtask

    // one request of any kind, any key code, any target bits
    task automatic send_noise_request();
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        key  = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 15)) : pick_step_key();
        if (pick < 8)       key = KEY_SELECT;
        else if (pick < 14) key = KEY_RUN;
        else if (pick < 17) key = KEY_STOP;
        if (pick < 45)      send_key(key);
        else if (pick < 65) send_request(REQ_TICK, key, rand_word());
        else if (pick < 70) send_request(REQ_READY, key, rand_word());
        else if (pick < 74) send_request(REQ_NOT_READY, key, rand_word());
        else if (pick < 78) send_request(REQ_TIMER_ON, key, rand_word());
        else if (pick < 82) send_request(REQ_TIMER_OFF, key, rand_word());
        else if (pick < 92) send_request(REQ_LED, key, rand_word());
        else                send_request(REQ_SET_TARGET, key, rand_word());
    endtask

    // A full cooking session: set minutes and seconds, leave edit mode, usually
    // get ready, start, then count down with the odd panel event in between.
    task automatic send_cook_cycle();
        int unsigned ticks;
        while (edit_q != EDIT_MIN) send_key(KEY_SELECT);
        repeat ($urandom_range(0, 3)) send_key(pick_step_key());
        repeat ($urandom_range(1, 3)) send_key(KEY_M100);
        repeat ($urandom_range(0, 2)) send_key(KEY_P1);
        send_key(KEY_SELECT);
        repeat ($urandom_range(0, 2)) send_key(KEY_M100);
        repeat ($urandom_range(0, 2)) send_key($urandom_range(0, 1) ? KEY_P10 : KEY_P1);
        send_key(KEY_SELECT);
        if ($urandom_range(0, 3) != 0) send_request(REQ_READY, KEY_RUN, rand_word());
        repeat ($urandom_range(0, 1)) send_key($urandom_range(0, 1) ? KEY_P1 : KEY_M1);
        send_key(KEY_RUN);
        ticks = $urandom_range(3, 45);
        repeat (ticks) begin
            case ($urandom_range(0, 19))
                0: send_request(REQ_LED, KEY_STOP, rand_word());
                1: send_request($urandom_range(0, 1) ? REQ_TIMER_ON : REQ_TIMER_OFF,
                                KEY_RUN, rand_word());
                2: send_noise_request();
                3: send_key(pick_step_key());           // ignored while running
                default: send_request(REQ_TICK, KEY_P1, rand_word());
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // target extremes, preset walk both ways, fan toggle, unused key, every
    // step key on the temperature field with clamping, and run refused
    // while a field is selected
    task automatic test_edit_and_presets();
        wait_for_results();
        plan_reset_limits();
        cfg_plan[CFG_PRE_TEMP] = {16'sd250, 16'sd200, 16'sd50, -16'sd100};
        cfg_plan[CFG_PRE_MIN]  = {16'sd30, 16'sd10, 16'sd5, 16'sd1};
        program_registers();
        pacing_on = 1'b1;
        send_request(REQ_SET_TARGET, KEY_UNUSED_LO, WORD_MAX);
        send_request(REQ_SET_TARGET, KEY_P100, WORD_MIN);
        send_key(KEY_P1);
        send_key(KEY_P1);
        send_key(KEY_M1);
        send_key(KEY_M100);
        send_key(KEY_UNUSED_HI);
        send_key(KEY_SELECT);           // temperature
        send_key(KEY_P100);
        send_key(KEY_P10);
        send_key(KEY_P1);
        send_key(KEY_M100);
        send_key(KEY_M10);
        send_key(KEY_M1);
        send_key(KEY_SELECT);           // minutes
        send_key(KEY_P1);
        send_key(KEY_SELECT);           // seconds
        send_key(KEY_P1);
        send_key(KEY_RUN);
        send_key(KEY_SELECT);           // back to none
    endtask

    // run with the timer picked up, step keys ignored, minute borrow with a
    // short reload, stop at zero, LED in all three ready / timer states
    task automatic test_countdown();
        int unsigned guard;
        guard = 0;
        wait_for_results();
        cfg_plan[CFG_MAX_SEC] = as_reg(16'sd2);
        program_registers();
        send_request(REQ_READY, KEY_P1, rand_word());
        send_key(KEY_RUN);
        send_request(REQ_LED, KEY_P1, rand_word());
        send_key(KEY_P100);
        while (run_q && guard < 12) begin
            send_request(REQ_TICK, KEY_P1, rand_word());
            guard++;
        end
        send_request(REQ_TIMER_OFF, KEY_P1, rand_word());
        send_request(REQ_LED, KEY_P1, rand_word());
        send_request(REQ_NOT_READY, KEY_P1, rand_word());
        send_request(REQ_LED, KEY_P1, rand_word());
        send_request(REQ_LED, KEY_P1, rand_word());
        send_key(KEY_STOP);
    endtask

    // receiver holds off while requests keep coming back to back, so the
    // output register and the sequencer fill and the request side stalls
    task automatic test_backpressure();
        wait_for_results();
        pacing_on       = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (24) send_noise_request();
        pacing_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_phases();
        int unsigned phase_end;
        t_word       lo;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_results();
            cfg_plan[CFG_PRE_TEMP] = pick_presets();
            cfg_plan[CFG_PRE_MIN]  = pick_presets();
            case (phase)
                0: plan_reset_limits();
                1: begin
                    // widest limits and temperature presets at the word extremes
                    cfg_plan[CFG_MAX_TEMP] = as_reg(WORD_MAX);
                    cfg_plan[CFG_MIN_TEMP] = as_reg(WORD_MIN);
                    cfg_plan[CFG_MAX_MIN]  = as_reg(WORD_MAX);
                    cfg_plan[CFG_MIN_MIN]  = as_reg(WORD_MIN);
                    cfg_plan[CFG_MAX_SEC]  = as_reg(WORD_MAX);
                    cfg_plan[CFG_MIN_SEC]  = as_reg(WORD_MIN);
                    cfg_plan[CFG_PRE_TEMP] = {WORD_MAX, 16'sd0, -16'sd1, WORD_MIN};
                end
                2: begin
                    // upper limit below lower limit (unless the subtraction wraps)
                    lo = pick_limit();
                    cfg_plan[CFG_MIN_TEMP] = as_reg(lo);
                    cfg_plan[CFG_MAX_TEMP] = as_reg(lo - t_word'($urandom_range(1, 50)));
                    lo = pick_limit();
                    cfg_plan[CFG_MIN_MIN]  = as_reg(lo);
                    cfg_plan[CFG_MAX_MIN]  = as_reg(lo - t_word'($urandom_range(1, 50)));
                    cfg_plan[CFG_MAX_SEC]  = as_reg(WORD_MIN);
                    cfg_plan[CFG_MIN_SEC]  = as_reg(WORD_MAX);
                end
                3: begin
                    // short timer so countdowns run to completion often
                    plan_reset_limits();
                    cfg_plan[CFG_MAX_MIN] = as_reg(16'sd2);
                    cfg_plan[CFG_MAX_SEC] = as_reg(16'sd3);
                end
                default: begin
                    cfg_plan[CFG_MAX_TEMP] = as_reg(pick_limit());
                    cfg_plan[CFG_MIN_TEMP] = as_reg(pick_limit());
                    cfg_plan[CFG_MAX_MIN]  = as_reg(pick_limit());
                    cfg_plan[CFG_MIN_MIN]  = as_reg(pick_limit());
                    cfg_plan[CFG_MAX_SEC]  = as_reg(pick_limit());
                    cfg_plan[CFG_MIN_SEC]  = as_reg(pick_limit());
                end
            endcase
            program_registers();
            pacing_on = (phase != 5);   // one phase with the sender never idle
            phase_end = requests_sent + ITEMS_PER_PHASE;
            while (requests_sent < phase_end) begin
                if ($urandom_range(0, 99) < 60) send_cook_cycle();
                else repeat (8) send_noise_request();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        requests_sent   = 0;
        results_checked = 0;
        mismatch_count  = 0;
        hold_off_cycles = 0;
        burst_left      = 0;
        pacing_on       = 1'b0;
        reset_panel_model();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_KEY;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MAX_TEMP;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edit_and_presets();
        test_countdown();
        test_backpressure();
        test_random_phases();
        wait_for_results();

        if (mismatch_count == 0 && expected_panel_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
